/* hw/rtl/stng_pkg.sv */
// Shared types, widths and constants of the square tone / noise sound generator.
// Used by the interfaces, the channel step unit, the serial divider and the top level.
`default_nettype none

package stng_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CLOCKS_W  = 10;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned ATT_W     = 4;
  localparam int unsigned GAIN_W    = 12;
  localparam int unsigned SUM_W     = 28;
  localparam int unsigned STEPS_W   = 14;
  localparam int unsigned LEVEL_W   = 14;
  localparam int unsigned LFSR_W    = 16;
  localparam int unsigned NCTL_W    = 3;
  localparam int unsigned LATCH_W   = 3;
  localparam int unsigned CH_W      = 2;

  localparam int unsigned CLOCK_DIVIDE_DEF = 16;
  localparam int unsigned DECAY_LIMIT_DEF  = 8192;
  localparam int unsigned MAX_LEVEL        = 16000;

  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'h8000;
  localparam logic [ATT_W-1:0]  ATT_SILENT = 4'hF;
  localparam logic [CNT_W-1:0]  CNT_RESET  = 10'd1;
  localparam logic [CNT_W-1:0]  RATE_FAST  = 10'h010;
  localparam logic [CNT_W-1:0]  RATE_MID   = 10'h020;
  localparam logic [CNT_W-1:0]  RATE_SLOW  = 10'h040;
  localparam logic [CH_W-1:0]   NOISE_CH   = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RATE_SEL_FAST = 2'd0,
    RATE_SEL_MID  = 2'd1,
    RATE_SEL_SLOW = 2'd2,
    RATE_SEL_TONE = 2'd3
  } rate_sel_e;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             phase;
    logic             toggled;
  } chan_res_t;

  // Attenuator weight, 0 loudest and 15 silent.
  function automatic logic [GAIN_W-1:0] gain_lut(input logic [ATT_W-1:0] att);
    logic [GAIN_W-1:0] g;
    unique case (att)
      4'd0:    g = 12'd4000;
      4'd1:    g = 12'd3177;
      4'd2:    g = 12'd2524;
      4'd3:    g = 12'd2005;
      4'd4:    g = 12'd1592;
      4'd5:    g = 12'd1265;
      4'd6:    g = 12'd1005;
      4'd7:    g = 12'd798;
      4'd8:    g = 12'd634;
      4'd9:    g = 12'd503;
      4'd10:   g = 12'd400;
      4'd11:   g = 12'd318;
      4'd12:   g = 12'd252;
      4'd13:   g = 12'd201;
      4'd14:   g = 12'd159;
      default: g = 12'd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/stng_item_if.sv */
// Input channel of the sound generator: valid/ready plus the item payload.
// Depends on stng_pkg for field widths.
`default_nettype none

interface stng_item_if
  import stng_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [BYTE_W-1:0]   data_byte;
  logic [CLOCKS_W-1:0] clock_count;

  modport source (output valid, operation, data_byte, clock_count, input ready);
  modport sink   (input valid, operation, data_byte, clock_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stng_result_if.sv */
// Result channel of the sound generator: valid/ready plus the result payload.
// Depends on stng_pkg for field widths.
`default_nettype none

interface stng_result_if
  import stng_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] sample_level;
  logic               audible;

  modport source (output valid, sample_level, audible, input ready);
  modport sink   (input valid, sample_level, audible, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stng_chan.sv */
// Shared channel step unit: one down-counter decrement, reload and phase toggle.
// The sequencer feeds it one channel per cycle. Depends on stng_pkg.
`default_nettype none

module stng_chan
  import stng_pkg::*;
(
  input  wire logic [CNT_W-1:0] cnt_i,
  input  wire logic [CNT_W-1:0] reload_i,
  input  wire logic             phase_i,
  input  wire logic             hold_i,
  output chan_res_t             res_o
);

  logic [CNT_W-1:0] dec;

  assign dec = cnt_i - CNT_W'(1);

  always_comb begin
    res_o = '{cnt: cnt_i, phase: phase_i, toggled: 1'b0};
    if (hold_i) begin
      // zero period: force the output high, leave the counter
      res_o.phase = 1'b1;
    end else if (dec == '0) begin
      res_o.cnt     = reload_i;
      res_o.phase   = ~phase_i;
      res_o.toggled = 1'b1;
    end else begin
      res_o.cnt = dec;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stng_div.sv */
// Restoring serial divider, one quotient bit per cycle, for the averaged level.
// Depends on stng_pkg for the sum, step and level widths.
`default_nettype none

module stng_div
  import stng_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SUM_W-1:0]   dividend_i,
  input  wire logic [STEPS_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [LEVEL_W-1:0]      quotient_o
);

  localparam int unsigned ITER_W = $clog2(SUM_W);

  logic [STEPS_W-1:0] rem_q;
  logic [SUM_W-1:0]   quo_q;
  logic [STEPS_W-1:0] div_q;
  logic [ITER_W-1:0]  iter_q;
  logic               busy_q;
  logic               done_q;
  logic [STEPS_W+1:0] trial;
  logic               fits;

  assign trial = {1'b0, rem_q, quo_q[SUM_W-1]} - {2'b00, div_q};
  assign fits  = ~trial[STEPS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_W'(SUM_W - 1);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        // shift in the next dividend bit and keep the remainder if it fits
        rem_q <= fits ? trial[STEPS_W-1:0] : {rem_q[STEPS_W-2:0], quo_q[SUM_W-1]};
        quo_q <= {quo_q[SUM_W-2:0], fits};
        if (iter_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q - ITER_W'(1);
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[LEVEL_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/square_tone_noise_sound_generator_unit.sv */
// Square tone / noise sound generator: three tone channels and one noise channel.
//
// item_i (valid/ready) carries operation, data_byte and clock_count; every item
// gives exactly one beat on result_o with sample_level and audible.
//   write byte : latch/data register write; result through the finish state.
//   tick       : adds clock_count to the prescaler; each CLOCK_DIVIDE clocks
//                run one step (a check plus one cycle per channel through the
//                shared step unit), then the accumulator and step count are
//                halved once the count reaches DECAY_LIMIT.
//   sample     : averaged level through the serial divider, one quotient bit a
//                cycle; zero, without the divider, when no step has run since the last sample.
// One item is in flight at a time: item_i.ready is high only when idle.
// The finished result sits in an output register; if the receiver stalls, the
// block waits with that item until the register frees, then accepts the next.
// Reset: all attenuators silent, periods zero, counters one, noise shifter
// seeded with its top bit, accumulator cleared; the block is ready right away.
`default_nettype none

module square_tone_noise_sound_generator_unit
  import stng_pkg::*;
#(
  parameter int unsigned CLOCK_DIVIDE = CLOCK_DIVIDE_DEF,
  parameter int unsigned DECAY_LIMIT  = DECAY_LIMIT_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  stng_item_if.sink     item_i,
  stng_result_if.source result_o
);

  localparam int unsigned PRE_W = $clog2(CLOCK_DIVIDE + (1 << CLOCKS_W));

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_STEP,
    S_DECAY,
    S_DIV,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    tone_q [3];
  logic [NCTL_W-1:0]   nctl_q;
  logic [ATT_W-1:0]    att_q [4];
  logic [CNT_W-1:0]    cnt_q [4];
  logic [3:0]          phase_q;
  logic [LFSR_W-1:0]   lfsr_q;
  logic [LATCH_W-1:0]  latch_q;
  logic [PRE_W-1:0]    pre_q;
  logic [SUM_W-1:0]    sum_q;
  logic [STEPS_W-1:0]  steps_q;
  logic [CH_W-1:0]     ch_q;
  logic [LEVEL_W-1:0]  sample_q;
  logic                out_valid_q;
  logic [LEVEL_W-1:0]  out_level_q;
  logic                out_aud_q;

  logic                accept;
  logic                out_free;
  logic [LATCH_W-1:0]  reg_sel;
  logic [CH_W-1:0]     reg_chan;
  logic [CNT_W-1:0]    rate;
  logic [CNT_W-1:0]    reload;
  logic                hold;
  chan_res_t           res;
  logic                fb;
  logic [LFSR_W-1:0]   lfsr_next;
  logic                lvl_bit;
  logic [SUM_W-1:0]    gain_ext;
  logic                audible;
  logic                div_start;
  logic                div_done;
  logic [LEVEL_W-1:0]  quotient;

  assign accept   = item_i.valid && item_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign reg_sel  = item_i.data_byte[7] ? item_i.data_byte[6:4] : latch_q;
  assign reg_chan = reg_sel[2:1];
  assign audible  = (att_q[0] != ATT_SILENT) || (att_q[1] != ATT_SILENT) ||
                    (att_q[2] != ATT_SILENT) || (att_q[3] != ATT_SILENT);

  always_comb begin
    unique case (rate_sel_e'(nctl_q[1:0]))
      RATE_SEL_FAST: rate = RATE_FAST;
      RATE_SEL_MID:  rate = RATE_MID;
      RATE_SEL_SLOW: rate = RATE_SLOW;
      RATE_SEL_TONE: rate = (tone_q[2] == '0) ? CNT_RESET : tone_q[2];
      default:       rate = RATE_FAST;
    endcase
  end

  always_comb begin
    unique case (ch_q)
      2'd0:    begin reload = tone_q[0]; hold = (tone_q[0] == '0); end
      2'd1:    begin reload = tone_q[1]; hold = (tone_q[1] == '0); end
      2'd2:    begin reload = tone_q[2]; hold = (tone_q[2] == '0); end
      default: begin reload = rate;      hold = 1'b0;              end
    endcase
  end

  stng_chan u_chan (
    .cnt_i    (cnt_q[ch_q]),
    .reload_i (reload),
    .phase_i  (phase_q[ch_q]),
    .hold_i   (hold),
    .res_o    (res)
  );

  // white noise taps bits 0 and 3, periodic noise recirculates bit 0
  assign fb        = nctl_q[2] ? (lfsr_q[0] ^ lfsr_q[3]) : lfsr_q[0];
  assign lfsr_next = (ch_q == NOISE_CH && res.toggled && res.phase) ?
                     {fb, lfsr_q[LFSR_W-1:1]} : lfsr_q;
  assign lvl_bit   = (ch_q == NOISE_CH) ? lfsr_next[0] : res.phase;
  assign gain_ext  = lvl_bit ? SUM_W'(gain_lut(att_q[ch_q])) : '0;

  assign div_start = accept && op_e'(item_i.operation) == OP_SAMPLE && steps_q != '0;

  stng_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (steps_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tone_q      <= '{default: '0};
      nctl_q      <= '0;
      att_q       <= '{default: ATT_SILENT};
      cnt_q       <= '{default: CNT_RESET};
      phase_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      latch_q     <= '0;
      pre_q       <= '0;
      sum_q       <= '0;
      steps_q     <= '0;
      ch_q        <= '0;
      sample_q    <= '0;
      out_valid_q <= 1'b0;
      out_level_q <= '0;
      out_aud_q   <= 1'b0;
    end else begin
      // the finish state sets the output register itself
      if (result_o.ready && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            sample_q <= '0;
            unique case (item_i.operation)
              OP_WRITE: begin
                state_q <= S_FINISH;
                if (item_i.data_byte[7]) begin
                  latch_q <= item_i.data_byte[6:4];
                end
                if (reg_sel[0]) begin
                  att_q[reg_chan] <= item_i.data_byte[ATT_W-1:0];
                end else if (reg_chan == NOISE_CH) begin
                  nctl_q <= item_i.data_byte[NCTL_W-1:0];
                  lfsr_q <= LFSR_SEED;
                end else if (item_i.data_byte[7]) begin
                  tone_q[reg_chan] <= {tone_q[reg_chan][CNT_W-1:4], item_i.data_byte[3:0]};
                end else begin
                  tone_q[reg_chan] <= {item_i.data_byte[5:0], tone_q[reg_chan][3:0]};
                end
              end
              OP_TICK: begin
                pre_q   <= pre_q + PRE_W'(item_i.clock_count);
                state_q <= S_TICK;
              end
              OP_SAMPLE: begin
                if (steps_q != '0) begin
                  state_q <= S_DIV;
                end else begin
                  sum_q   <= '0;
                  state_q <= S_FINISH;
                end
              end
              default: state_q <= S_FINISH;
            endcase
          end
        end
        S_TICK: begin
          if (pre_q >= PRE_W'(CLOCK_DIVIDE)) begin
            pre_q   <= pre_q - PRE_W'(CLOCK_DIVIDE);
            ch_q    <= '0;
            state_q <= S_STEP;
          end else begin
            state_q <= S_DECAY;
          end
        end
        S_STEP: begin
          // advance one channel and fold its level into the accumulator
          cnt_q[ch_q]   <= res.cnt;
          phase_q[ch_q] <= res.phase;
          lfsr_q        <= lfsr_next;
          sum_q         <= sum_q + gain_ext;
          ch_q          <= ch_q + CH_W'(1);
          if (ch_q == NOISE_CH) begin
            steps_q <= steps_q + STEPS_W'(1);
            state_q <= S_TICK;
          end
        end
        S_DECAY: begin
          if (steps_q >= STEPS_W'(DECAY_LIMIT)) begin
            sum_q   <= sum_q >> 1;
            steps_q <= steps_q >> 1;
          end
          state_q <= S_FINISH;
        end
        S_DIV: begin
          if (div_done) begin
            sample_q <= quotient;
            sum_q    <= '0;
            steps_q  <= '0;
            state_q  <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold the result until the output register frees
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_level_q <= sample_q;
            out_aud_q   <= audible;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign item_i.ready          = (state_q == S_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.sample_level = out_level_q;
  assign result_o.audible      = out_aud_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !item_i.ready)
    else $error("input accepted twice in a row");

  a_prescaler_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> pre_q < PRE_W'(CLOCK_DIVIDE))
    else $error("prescaler left at or above the divide");

  a_steps_decayed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> steps_q < STEPS_W'(DECAY_LIMIT))
    else $error("step count not decayed after tick");

  a_step_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEP && ch_q == NOISE_CH |=> steps_q == $past(steps_q) + STEPS_W'(1))
    else $error("step not counted after last channel");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_level_q <= LEVEL_W'(MAX_LEVEL))
    else $error("averaged level above full scale");

endmodule

`default_nettype wire

/* tb/sv/stng_level_checker.sv */
// Checker for the square tone / noise sound generator: watches the item and result
// channels, predicts each result beat from its own channel model and compares them.
// Depends on stng_pkg and the stng_item_if / stng_result_if interfaces.
`timescale 1ns / 100ps

module stng_level_checker
  import stng_pkg::*;
#(
  parameter int unsigned CLOCK_DIVIDE = CLOCK_DIVIDE_DEF,
  parameter int unsigned DECAY_LIMIT  = DECAY_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stng_item_if        item_i,
  stng_result_if      result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o,
  output int unsigned loud_sample_count_o,
  output int unsigned halving_count_o
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               audible;
  } level_beat_t;

  localparam int unsigned ATT_WEIGHT [16] = '{
    4000, 3177, 2524, 2005, 1592, 1265, 1005, 798,
    634, 503, 400, 318, 252, 201, 159, 0
  };

  logic [CNT_W-1:0]   period_q  [3];
  logic [ATT_W-1:0]   atten_q   [4];
  logic [CNT_W-1:0]   count_q   [4];
  logic               phase_q   [4];
  logic [NCTL_W-1:0]  noise_ctl_q;
  logic [LFSR_W-1:0]  shifter_q;
  logic [LATCH_W-1:0] latched_q;
  int unsigned        prescale_q;
  int unsigned        sum_q;
  int unsigned        steps_q;

  level_beat_t expected_levels [$];

  function automatic void write_register(input logic [LATCH_W-1:0] sel,
                                         input logic [BYTE_W-1:0] b, input logic is_latch);
    logic [CH_W-1:0] chan;
    chan = sel[2:1];
    if (sel[0]) begin
      atten_q[chan] = b[3:0];
    end else if (chan == NOISE_CH) begin
      noise_ctl_q = b[NCTL_W-1:0];
      shifter_q   = LFSR_SEED;
    end else if (is_latch) begin
      period_q[chan] = {period_q[chan][CNT_W-1:4], b[3:0]};
    end else begin
      period_q[chan] = {b[5:0], period_q[chan][3:0]};
    end
  endfunction

  function automatic void advance_step();
    int unsigned lvl;
    int          ch;
    logic        fb;
    lvl = 0;
    for (ch = 0; ch < 3; ch++) begin
      if (period_q[ch] == '0) begin
        phase_q[ch] = 1'b1;
      end else begin
        count_q[ch] = count_q[ch] - 1'b1;
        if (count_q[ch] == '0) begin
          count_q[ch] = period_q[ch];
          phase_q[ch] = ~phase_q[ch];
        end
      end
    end
    count_q[NOISE_CH] = count_q[NOISE_CH] - 1'b1;
    if (count_q[NOISE_CH] == '0) begin
      case (rate_sel_e'(noise_ctl_q[1:0]))
        RATE_SEL_FAST: count_q[NOISE_CH] = RATE_FAST;
        RATE_SEL_MID:  count_q[NOISE_CH] = RATE_MID;
        RATE_SEL_SLOW: count_q[NOISE_CH] = RATE_SLOW;
        default:       count_q[NOISE_CH] = (period_q[2] != '0) ? period_q[2] : 10'd1;
      endcase
      phase_q[NOISE_CH] = ~phase_q[NOISE_CH];
      // shift only on the rising toggle
      if (phase_q[NOISE_CH]) begin
        fb        = noise_ctl_q[2] ? (shifter_q[0] ^ shifter_q[3]) : shifter_q[0];
        shifter_q = {fb, shifter_q[LFSR_W-1:1]};
      end
    end
    for (ch = 0; ch < 3; ch++) begin
      if (phase_q[ch]) lvl += ATT_WEIGHT[atten_q[ch]];
    end
    if (shifter_q[0]) lvl += ATT_WEIGHT[atten_q[NOISE_CH]];
    sum_q   += lvl;
    steps_q += 1;
  endfunction

  function automatic level_beat_t predict_level(input logic [OP_W-1:0] op,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [CLOCKS_W-1:0] clocks);
    level_beat_t r;
    int          ch;
    r.level   = '0;
    r.audible = 1'b0;
    case (op)
      OP_WRITE: begin
        if (b[7]) begin
          latched_q = b[6:4];
          write_register(latched_q, b, 1'b1);
        end else begin
          write_register(latched_q, b, 1'b0);
        end
      end
      OP_TICK: begin
        prescale_q += clocks;
        while (prescale_q >= CLOCK_DIVIDE) begin
          prescale_q -= CLOCK_DIVIDE;
          advance_step();
        end
        if (steps_q >= DECAY_LIMIT) begin
          sum_q   = sum_q / 2;
          steps_q = steps_q / 2;
          halving_count_o++;
        end
      end
      OP_SAMPLE: begin
        r.level = (steps_q != 0) ? LEVEL_W'(sum_q / steps_q) : '0;
        sum_q   = 0;
        steps_q = 0;
      end
      default: ;
    endcase
    for (ch = 0; ch < 4; ch++) begin
      if (atten_q[ch] != ATT_SILENT) r.audible = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_beat_t got;
    level_beat_t want;
    int          ch;
    if (!rst_ni) begin
      for (ch = 0; ch < 3; ch++) period_q[ch] = '0;
      for (ch = 0; ch < 4; ch++) begin
        atten_q[ch] = ATT_SILENT;
        count_q[ch] = CNT_RESET;
        phase_q[ch] = 1'b0;
      end
      noise_ctl_q         = '0;
      shifter_q           = LFSR_SEED;
      latched_q           = '0;
      prescale_q          = 0;
      sum_q               = 0;
      steps_q             = 0;
      expected_levels.delete();
      fail_count_o        = 0;
      pending_o           = 0;
      result_count_o      = 0;
      loud_sample_count_o = 0;
      halving_count_o     = 0;
    end else begin
      // compare first: a beat leaving this edge belongs to an older item
      if (result_i.valid && result_i.ready) begin
        got.level   = result_i.sample_level;
        got.audible = result_i.audible;
        result_count_o++;
        if (expected_levels.size() == 0) begin
          $display("%0t: result beat with nothing expected, level %0d audible %0b",
                   $time, got.level, got.audible);
          fail_count_o++;
        end else begin
          want = expected_levels.pop_front();
          if (got.level !== want.level) begin
            $display("%0t: sample_level mismatch, expected %0d, actual %0d",
                     $time, want.level, got.level);
            fail_count_o++;
          end
          if (got.audible !== want.audible) begin
            $display("%0t: audible mismatch, expected %0b, actual %0b",
                     $time, want.audible, got.audible);
            fail_count_o++;
          end
          if (want.level != '0) loud_sample_count_o++;
        end
      end
      if (item_i.valid && item_i.ready) begin
        expected_levels.push_back(predict_level(item_i.operation, item_i.data_byte,
                                                item_i.clock_count));
      end
      pending_o = expected_levels.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the sound generator testbench: clock, reset, item stimulus and result drain.
// Instantiates square_tone_noise_sound_generator_unit and stng_level_checker.
`timescale 1ns / 100ps

module tb_top;
  import stng_pkg::*;

  localparam int unsigned CLK_DIV        = CLOCK_DIVIDE_DEF;
  localparam int unsigned DECAY          = DECAY_LIMIT_DEF;
  localparam int unsigned ITEM_TARGET    = 1150;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned HOLD_AT        = 3000;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned DRAIN_CYCLES   = 400;
  localparam int unsigned LONG_RUN_TICKS = 180;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam logic            REG_PERIOD  = 1'b0;
  localparam logic            REG_ATTEN   = 1'b1;
  localparam logic            NOISE_WHITE = 1'b1;
  localparam logic            NOISE_PER   = 1'b0;

  logic clk = 1'b0;
  logic rst_n;

  stng_item_if   item_ch ();
  stng_result_if res_ch ();

  int unsigned fail_count, pending, result_count, loud_samples, halvings;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned op_count [4];

  square_tone_noise_sound_generator_unit #(
    .CLOCK_DIVIDE (CLK_DIV),
    .DECAY_LIMIT  (DECAY)
  ) u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_ch),
    .result_o (res_ch)
  );

  stng_level_checker #(
    .CLOCK_DIVIDE (CLK_DIV),
    .DECAY_LIMIT  (DECAY)
  ) u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .item_i              (item_ch),
    .result_i            (res_ch),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .result_count_o      (result_count),
    .loud_sample_count_o (loud_samples),
    .halving_count_o     (halvings)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] latch_byte(input logic [CH_W-1:0] chan,
                                                   input logic kind, input logic [3:0] nib);
    return {1'b1, chan, kind, nib};
  endfunction

  function automatic logic [ATT_W-1:0] pick_atten();
    return ($urandom_range(0, 4) == 0) ? ATT_SILENT : ATT_W'($urandom_range(0, 15));
  endfunction

  // Offer one beat; the sender works in bursts with random gaps between them.
  task automatic offer(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                       input logic [CLOCKS_W-1:0] clocks);
    if (burst_left == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    item_ch.valid       <= 1'b1;
    item_ch.operation   <= op;
    item_ch.data_byte   <= b;
    item_ch.clock_count <= clocks;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    op_count[op]++;
    items_sent++;
  endtask

  task automatic send_period(input logic [CH_W-1:0] chan, input logic [CNT_W-1:0] period);
    offer(OP_WRITE, latch_byte(chan, REG_PERIOD, period[3:0]), CLOCKS_W'($urandom));
    // bit 6 of the data byte is ignored for a period; randomize it
    offer(OP_WRITE, {1'b0, 1'($urandom), period[9:4]}, CLOCKS_W'($urandom));
  endtask

  task automatic set_atten(input logic [CH_W-1:0] chan, input logic [ATT_W-1:0] att);
    offer(OP_WRITE, latch_byte(chan, REG_ATTEN, att), CLOCKS_W'($urandom));
  endtask

  task automatic tick(input logic [CLOCKS_W-1:0] clocks);
    offer(OP_TICK, BYTE_W'($urandom), clocks);
  endtask

  task automatic take_sample();
    offer(OP_SAMPLE, BYTE_W'($urandom), CLOCKS_W'($urandom));
  endtask

  // Result drain: runs of ready and stalls, plus one long hold-off.
  initial begin : result_drain
    int unsigned cyc;
    int unsigned run;
    logic        take;
    res_ch.ready <= 1'b0;
    cyc  = 0;
    run  = 0;
    take = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_AT) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        cyc += HOLD_CYCLES;
      end
      if (run == 0) begin
        take = ~take;
        if (take) run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
        else      run = $urandom_range(1, 5);
      end
      res_ch.ready <= take;
      run--;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat on either channel for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned        long_runs;
    int unsigned        n;
    logic [CH_W-1:0]    chan;
    logic [CNT_W-1:0]   period;
    logic [CLOCKS_W-1:0] clocks;
    item_ch.valid       <= 1'b0;
    item_ch.operation   <= OP_WRITE;
    item_ch.data_byte   <= '0;
    item_ch.clock_count <= '0;
    rst_n               <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    long_runs  = 0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty average, unused operation, empty tick, field extremes
    take_sample();
    offer(OP_UNUSED, 8'hFF, 10'h3FF);
    tick(10'd0);
    set_atten(2'd0, 4'd0);
    send_period(2'd0, 10'h3FF);
    send_period(2'd1, 10'd1);
    // tone 2 keeps a zero period: its output holds high
    set_atten(2'd2, 4'd14);
    // white noise at the tone 2 rate while that period is still zero
    offer(OP_WRITE, latch_byte(NOISE_CH, REG_PERIOD, {1'b0, NOISE_WHITE, RATE_SEL_TONE}), '0);
    set_atten(NOISE_CH, 4'd0);
    tick(10'h3FF);
    take_sample();
    offer(OP_WRITE, latch_byte(NOISE_CH, REG_PERIOD, {1'b0, NOISE_PER, RATE_SEL_FAST}), '0);
    // data byte to the latched noise register reseeds the shifter
    offer(OP_WRITE, {1'b0, 4'b0000, NOISE_WHITE, RATE_SEL_MID}, '0);
    tick(10'h3FF);
    take_sample();
    send_period(2'd2, 10'h013);
    offer(OP_WRITE, latch_byte(NOISE_CH, REG_PERIOD, {1'b0, NOISE_PER, RATE_SEL_TONE}), '0);
    tick(10'd700);
    take_sample();
    for (int i = 0; i < 4; i++) set_atten(CH_W'(i), ATT_SILENT);
    tick(10'd300);
    take_sample();

    while (items_sent < ITEM_TARGET) begin
      if (long_runs < 2 && items_sent > 300 + long_runs * 400) begin
        // long stretch without a sample drives the accumulator into its halving
        set_atten(CH_W'($urandom_range(0, 2)), ATT_W'($urandom_range(0, 14)));
        repeat (LONG_RUN_TICKS) tick(CLOCKS_W'($urandom_range(700, 1023)));
        take_sample();
        long_runs++;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            chan = CH_W'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
              0:       period = '0;
              1:       period = CNT_W'($urandom_range(1, 15));
              default: period = CNT_W'($urandom);
            endcase
            send_period(chan, period);
            if ($urandom_range(0, 1)) set_atten(chan, pick_atten());
          end
          3: begin
            offer(OP_WRITE, latch_byte(NOISE_CH, REG_PERIOD, 4'($urandom)), CLOCKS_W'($urandom));
            if ($urandom_range(0, 2) == 0) offer(OP_WRITE, {1'b0, 7'($urandom)}, '0);
            if ($urandom_range(0, 1)) set_atten(NOISE_CH, pick_atten());
          end
          4, 5, 6, 7: begin
            n = $urandom_range(1, 5);
            repeat (n) begin
              clocks = ($urandom_range(0, 4) == 0) ? CLOCKS_W'($urandom_range(0, 31))
                                                   : CLOCKS_W'($urandom);
              tick(clocks);
            end
            if ($urandom_range(0, 4) != 0) take_sample();
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       offer(OP_UNUSED, BYTE_W'($urandom), CLOCKS_W'($urandom));
              1:       offer(OP_WRITE, {1'b0, 7'($urandom)}, CLOCKS_W'($urandom));
              2:       offer(OP_WRITE, {1'b1, 7'($urandom)}, CLOCKS_W'($urandom));
              default: offer(OP_W'($urandom), BYTE_W'($urandom), CLOCKS_W'($urandom));
            endcase
          end
        endcase
      end
    end

    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d writes, %0d ticks, %0d samples, %0d unused operations.",
             op_count[OP_WRITE], op_count[OP_TICK], op_count[OP_SAMPLE], op_count[OP_UNUSED]);
    $display("Checked %0d result beats: %0d nonzero averages, %0d accumulator halvings.",
             result_count, loud_samples, halvings);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* square_tone_noise_sound_generator_unit.f */
hw/rtl/stng_pkg.sv
hw/rtl/stng_item_if.sv
hw/rtl/stng_result_if.sv
hw/rtl/stng_chan.sv
hw/rtl/stng_div.sv
hw/rtl/square_tone_noise_sound_generator_unit.sv
tb/sv/stng_level_checker.sv
tb/sv/tb_top.sv
